[rtl/kgeb_pkg.sv]
// kgeb_pkg: shared constants, register indexes and controller/datapath
// command and status types for the knn graph edge builder
// no dependencies
`timescale 1ns / 1ps

package kgeb_pkg;

    // fixed field widths
    localparam int NODE_W      = 6;
    localparam int TOPK_W      = 6;
    localparam int MINSEP_W    = 10;
    localparam int NCOUNT_W    = 7;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 10;

    // default parameter values
    localparam int DEF_MAX_NODES    = 64;
    localparam int DEF_COORD_BITS   = 20;
    localparam int DEF_RESIDUE_BITS = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TOP_K      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SEP    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_NODE_COUNT = 2'd2;

    // register reset values
    localparam logic [TOPK_W-1:0]   RST_TOP_K      = 6'd8;
    localparam logic [MINSEP_W-1:0] RST_MIN_SEP    = 10'd0;
    localparam logic [NCOUNT_W-1:0] RST_NODE_COUNT = 7'd64;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic              accept;
        logic              load_we;
        logic              rd_en;
        logic              rd_src;
        logic [NODE_W-1:0] j;
        logic              p1_issue;
        logic              latch_src;
        logic              build_mask;
        logic              p2_issue;
        logic              take_pend;
        logic              push_pend;
        logic              push_final;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [NCOUNT_W-1:0] n_part;
        logic                src_ok;
        logic                busy;
        logic                hit;
        logic                pend_v;
        logic                out_free;
        logic [NODE_W-1:0]   node;
    } t_sts;

endpackage

[rtl/kgeb_ram.sv]
// kgeb_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module kgeb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/kgeb_ctrl.sv]
// kgeb_ctrl: sequencer for load, ranking pass and edge emission pass
// depends on kgeb_pkg
`timescale 1ns / 1ps

module kgeb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_s_kind,
    output logic          o_s_ready,
    input  kgeb_pkg::t_sts i_sts,
    output kgeb_pkg::t_cmd o_cmd
);
    import kgeb_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SRC  = 4'd1;
    localparam logic [3:0] ST_SRCW = 4'd2;
    localparam logic [3:0] ST_P1   = 4'd3;
    localparam logic [3:0] ST_MASK = 4'd4;
    localparam logic [3:0] ST_P2RD = 4'd5;
    localparam logic [3:0] ST_P2WT = 4'd6;
    localparam logic [3:0] ST_P2EV = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [NCOUNT_W-1:0] r_cnt, n_cnt;
    t_cmd                w_cmd;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_cmd   = '0;
        w_cmd.j = r_cnt[NODE_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    w_cmd.accept = 1'b1;
                    if (i_s_kind == REQ_QUERY) begin
                        n_cnt   = '0;
                        n_state = i_sts.src_ok ? ST_SRC : ST_FIN;
                    end else begin
                        w_cmd.load_we = i_sts.src_ok;
                    end
                end
            end
            ST_SRC: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_src = 1'b1;
                n_state      = ST_SRCW;
            end
            ST_SRCW: begin
                w_cmd.latch_src = 1'b1;
                n_state         = ST_P1;
            end
            ST_P1: begin
                // one distance read per cycle, then let the pipeline drain
                if (r_cnt < i_sts.n_part) begin
                    w_cmd.rd_en    = 1'b1;
                    w_cmd.p1_issue = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                end else if (!i_sts.busy) begin
                    n_state = ST_MASK;
                end
            end
            ST_MASK: begin
                w_cmd.build_mask = 1'b1;
                n_cnt            = '0;
                n_state          = ST_P2RD;
            end
            ST_P2RD: begin
                if (r_cnt >= i_sts.n_part) begin
                    n_state = ST_FIN;
                end else if (r_cnt[NODE_W-1:0] == i_sts.node) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    w_cmd.rd_en = 1'b1;
                    n_state     = ST_P2WT;
                end
            end
            ST_P2WT: begin
                w_cmd.p2_issue = 1'b1;
                n_state        = ST_P2EV;
            end
            ST_P2EV: begin
                // an edge is held back one step so the final one can carry last
                if (i_sts.hit) begin
                    if (i_sts.pend_v) begin
                        if (i_sts.out_free) begin
                            w_cmd.push_pend = 1'b1;
                            w_cmd.take_pend = 1'b1;
                            n_cnt           = r_cnt + 1'b1;
                            n_state         = ST_P2RD;
                        end
                    end else begin
                        w_cmd.take_pend = 1'b1;
                        n_cnt           = r_cnt + 1'b1;
                        n_state         = ST_P2RD;
                    end
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_P2RD;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    w_cmd.push_final = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_cmd     = w_cmd;

endmodule

[rtl/kgeb_dpath.sv]
// kgeb_dpath: node stores, distance pipeline, sorted nearest list,
// edge evaluation, pending edge and output register
// depends on kgeb_pkg and kgeb_ram
`timescale 1ns / 1ps

module kgeb_dpath #(
    parameter int MAX_NODES    = kgeb_pkg::DEF_MAX_NODES,
    parameter int COORD_BITS   = kgeb_pkg::DEF_COORD_BITS,
    parameter int RESIDUE_BITS = kgeb_pkg::DEF_RESIDUE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kgeb_pkg::t_cmd                    i_cmd,
    output kgeb_pkg::t_sts                    o_sts,
    input  logic [kgeb_pkg::NODE_W-1:0]       i_node,
    input  logic [COORD_BITS-1:0]             i_pos_x,
    input  logic [COORD_BITS-1:0]             i_pos_y,
    input  logic [COORD_BITS-1:0]             i_pos_z,
    input  logic [RESIDUE_BITS-1:0]           i_residue,
    input  logic                              i_cfg_valid,
    input  logic [kgeb_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [kgeb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [kgeb_pkg::NODE_W-1:0]       o_edge_source,
    output logic [kgeb_pkg::NODE_W-1:0]       o_edge_target,
    output logic [COORD_BITS:0]               o_delta_x,
    output logic [COORD_BITS:0]               o_delta_y,
    output logic [COORD_BITS:0]               o_delta_z,
    output logic                              o_no_edge,
    output logic                              o_last_edge
);
    import kgeb_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int R      = RESIDUE_BITS;
    localparam int SLOTS  = (MAX_NODES < 64) ? MAX_NODES : 64;
    localparam int AW     = $clog2(SLOTS);
    localparam int L      = SLOTS - 1;
    localparam int SQ_W   = 2 * C;
    localparam int SUM_W  = 2 * C + 2;
    localparam int DIST_W = (SUM_W > 64) ? 64 : SUM_W;
    localparam int SEP_W  = (R > MINSEP_W) ? R : MINSEP_W;

    // configuration registers
    logic [TOPK_W-1:0]   r_top_k;
    logic [MINSEP_W-1:0] r_min_sep;
    logic [NCOUNT_W-1:0] r_node_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_k      <= RST_TOP_K;
            r_min_sep    <= RST_MIN_SEP;
            r_node_count <= RST_NODE_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_TOP_K:      r_top_k      <= i_cfg_data[TOPK_W-1:0];
                CFG_MIN_SEP:    r_min_sep    <= i_cfg_data[MINSEP_W-1:0];
                CFG_NODE_COUNT: r_node_count <= i_cfg_data[NCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // queried node
    logic [NODE_W-1:0] r_node;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_node <= i_node;
        end
    end

    // node stores
    logic [3*C-1:0] w_cq;
    logic [R-1:0]   w_rq;
    logic [AW-1:0]  w_raddr;

    assign w_raddr = i_cmd.rd_src ? r_node[AW-1:0] : i_cmd.j[AW-1:0];

    kgeb_ram #(.WIDTH(3 * C), .DEPTH(SLOTS)) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (i_node[AW-1:0]),
        .i_wdata ({i_pos_z, i_pos_y, i_pos_x}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_cq)
    );

    kgeb_ram #(.WIDTH(R), .DEPTH(SLOTS)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (i_node[AW-1:0]),
        .i_wdata (i_residue),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rq)
    );

    // source node data
    logic [C-1:0] r_src_x, r_src_y, r_src_z;
    logic [R-1:0] r_src_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_src) begin
            r_src_x   <= w_cq[C-1:0];
            r_src_y   <= w_cq[2*C-1:C];
            r_src_z   <= w_cq[3*C-1:2*C];
            r_src_res <= w_rq;
        end
    end

    // target minus source on the ram output
    logic signed [C:0] w_dx, w_dy, w_dz;

    assign w_dx = signed'({w_cq[C-1], w_cq[C-1:0]}) - signed'({r_src_x[C-1], r_src_x});
    assign w_dy = signed'({w_cq[2*C-1], w_cq[2*C-1:C]}) - signed'({r_src_y[C-1], r_src_y});
    assign w_dz = signed'({w_cq[3*C-1], w_cq[3*C-1:2*C]}) - signed'({r_src_z[C-1], r_src_z});

    // distance pipeline: read, delta, square, sum
    logic              r_rd_v, r_dl_v, r_sq_v, r_sm_v;
    logic              r_rd_c, r_dl_c, r_sq_c, r_sm_c;
    logic [NODE_W-1:0] r_rd_j, r_dl_j, r_sq_j, r_sm_j;
    logic signed [C:0] r_dl_x, r_dl_y, r_dl_z;
    logic [C:0]        w_mx, w_my, w_mz;
    logic [SQ_W-1:0]   r_sq_x, r_sq_y, r_sq_z;
    logic [SUM_W-1:0]  w_sum;
    logic [DIST_W-1:0] w_dist, r_sm_d;

    assign w_mx = r_dl_x[C] ? (C + 1)'(-r_dl_x) : r_dl_x;
    assign w_my = r_dl_y[C] ? (C + 1)'(-r_dl_y) : r_dl_y;
    assign w_mz = r_dl_z[C] ? (C + 1)'(-r_dl_z) : r_dl_z;

    assign w_sum = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);

    // saturate at the distance width
    always_comb begin
        if (w_sum > SUM_W'({DIST_W{1'b1}})) begin
            w_dist = '1;
        end else begin
            w_dist = DIST_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_dl_v <= 1'b0;
            r_sq_v <= 1'b0;
            r_sm_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.p1_issue;
            r_dl_v <= r_rd_v;
            r_sq_v <= r_dl_v;
            r_sm_v <= r_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_j <= i_cmd.j;
        r_rd_c <= (i_cmd.j != r_node);
        r_dl_j <= r_rd_j;
        r_dl_c <= r_rd_c;
        r_dl_x <= w_dx;
        r_dl_y <= w_dy;
        r_dl_z <= w_dz;
        r_sq_j <= r_dl_j;
        r_sq_c <= r_dl_c;
        r_sq_x <= SQ_W'(w_mx[C-1:0]) * SQ_W'(w_mx[C-1:0]);
        r_sq_y <= SQ_W'(w_my[C-1:0]) * SQ_W'(w_my[C-1:0]);
        r_sq_z <= SQ_W'(w_mz[C-1:0]) * SQ_W'(w_mz[C-1:0]);
        r_sm_j <= r_sq_j;
        r_sm_c <= r_sq_c;
        r_sm_d <= w_dist;
    end

    // sorted nearest list, ascending distance, ties keep the earlier index
    logic              r_lv [L];
    logic [DIST_W-1:0] r_ld [L];
    logic [NODE_W-1:0] r_lx [L];
    logic              w_le [L];
    logic              w_prev_le [L];
    logic              w_up_v [L];
    logic [DIST_W-1:0] w_up_d [L];
    logic [NODE_W-1:0] w_up_x [L];
    logic              w_ins;

    assign w_ins = r_sm_v & r_sm_c;

    for (genvar g = 0; g < L; g++) begin : g_cell
        assign w_le[g] = r_lv[g] && (r_ld[g] <= r_sm_d);

        if (g == 0) begin : g_head
            assign w_prev_le[g] = 1'b1;
            assign w_up_v[g]    = 1'b1;
            assign w_up_d[g]    = r_sm_d;
            assign w_up_x[g]    = r_sm_j;
        end else begin : g_body
            assign w_prev_le[g] = w_le[g-1];
            assign w_up_v[g]    = r_lv[g-1];
            assign w_up_d[g]    = r_ld[g-1];
            assign w_up_x[g]    = r_lx[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || (i_cmd.accept && i_cmd.load_we == 1'b0)) begin
                r_lv[g] <= 1'b0;
            end else if (w_ins && !w_le[g]) begin
                r_lv[g] <= (w_prev_le[g] | w_up_v[g])
                           & (NCOUNT_W'(g) < {1'b0, r_top_k});
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ins && !w_le[g]) begin
                r_ld[g] <= w_prev_le[g] ? r_sm_d : w_up_d[g];
                r_lx[g] <= w_prev_le[g] ? r_sm_j : w_up_x[g];
            end
        end
    end

    // nearest mask from the list
    logic [SLOTS-1:0] w_mask, r_mask;

    always_comb begin
        w_mask = '0;
        for (int i = 0; i < L; i++) begin
            if (r_lv[i]) begin
                w_mask = w_mask | (SLOTS'(1) << r_lx[i][AW-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cmd.build_mask) begin
            r_mask <= w_mask;
        end
    end

    // edge evaluation for one target
    logic [R-1:0]      w_sep;
    logic              w_hit, r_cd_hit;
    logic [NODE_W-1:0] r_cd_j;
    logic [C:0]        r_cd_x, r_cd_y, r_cd_z;

    assign w_sep = (w_rq >= r_src_res) ? (w_rq - r_src_res) : (r_src_res - w_rq);
    assign w_hit = r_mask[i_cmd.j[AW-1:0]] | (SEP_W'(w_sep) < SEP_W'(r_min_sep));

    always_ff @(posedge i_clk) begin
        if (i_cmd.p2_issue) begin
            r_cd_hit <= w_hit;
            r_cd_j   <= i_cmd.j;
            r_cd_x   <= w_dx;
            r_cd_y   <= w_dy;
            r_cd_z   <= w_dz;
        end
    end

    // pending edge held until the next one or the end of the run
    logic              r_pd_v;
    logic [NODE_W-1:0] r_pd_j;
    logic [C:0]        r_pd_x, r_pd_y, r_pd_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.push_final) begin
            r_pd_v <= 1'b0;
        end else if (i_cmd.take_pend) begin
            r_pd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pend) begin
            r_pd_j <= r_cd_j;
            r_pd_x <= r_cd_x;
            r_pd_y <= r_cd_y;
            r_pd_z <= r_cd_z;
        end
    end

    // output register, source kept with the result so a new item cannot disturb it
    logic              r_out_v;
    logic [NODE_W-1:0] r_out_src;
    logic [NODE_W-1:0] r_out_tgt;
    logic [C:0]        r_out_x, r_out_y, r_out_z;
    logic              r_out_none, r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.push_pend || i_cmd.push_final) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_pend || (i_cmd.push_final && r_pd_v)) begin
            r_out_src  <= r_node;
            r_out_tgt  <= r_pd_j;
            r_out_x    <= r_pd_x;
            r_out_y    <= r_pd_y;
            r_out_z    <= r_pd_z;
            r_out_none <= 1'b0;
            r_out_last <= i_cmd.push_final;
        end else if (i_cmd.push_final) begin
            r_out_src  <= r_node;
            r_out_tgt  <= '0;
            r_out_x    <= '0;
            r_out_y    <= '0;
            r_out_z    <= '0;
            r_out_none <= 1'b1;
            r_out_last <= 1'b1;
        end
    end

    // status to the controller
    always_comb begin
        o_sts          = '0;
        o_sts.n_part   = (r_node_count > NCOUNT_W'(SLOTS)) ? NCOUNT_W'(SLOTS) : r_node_count;
        o_sts.src_ok   = (32'(i_node) < 32'(MAX_NODES));
        o_sts.busy     = r_rd_v | r_dl_v | r_sq_v | r_sm_v;
        o_sts.hit      = r_cd_hit;
        o_sts.pend_v   = r_pd_v;
        o_sts.out_free = !r_out_v | i_out_ready;
        o_sts.node     = r_node;
    end

    assign o_out_valid   = r_out_v;
    assign o_edge_source = r_out_src;
    assign o_edge_target = r_out_tgt;
    assign o_delta_x     = r_out_x;
    assign o_delta_y     = r_out_y;
    assign o_delta_z     = r_out_z;
    assign o_no_edge     = r_out_none;
    assign o_last_edge   = r_out_last;

endmodule

[rtl/knn_graph_edge_builder.sv]
// knn_graph_edge_builder: top level, k nearest neighbor edge builder with
// a sequence separation override; depends on kgeb_pkg, kgeb_ctrl, kgeb_dpath
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata node fields, tuser req_type
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata edge fields, tuser no_edge, tlast
// cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_addr index, i_cfg_data value
//
// a load is written to the node stores when it is taken; a query makes one coordinate ram
// read per node taking part in the ranking pass and lets the distance pipeline drain, then
// reads each of those nodes but the queried one again in the edge pass (shared single read
// port); a stalled output holds the edge pass until the result is taken
// i_rst_n is synchronous, active low; it clears control state and the config registers
// node stores are not cleared and hold unknown data until loaded
// one item is worked at a time; s_axis_tready is high only while the block is idle
`timescale 1ns / 1ps

module knn_graph_edge_builder #(
    parameter int  MAX_NODES    = kgeb_pkg::DEF_MAX_NODES,
    parameter int  COORD_BITS   = kgeb_pkg::DEF_COORD_BITS,
    parameter int  RESIDUE_BITS = kgeb_pkg::DEF_RESIDUE_BITS,
    localparam int IN_DATA_W    = ((kgeb_pkg::NODE_W + 3 * COORD_BITS + RESIDUE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W   = ((2 * kgeb_pkg::NODE_W + 3 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // node, pos_x, pos_y, pos_z, residue_number, zero fill
    input  logic [IN_DATA_W-1:0]            s_axis_tdata,
    // req_type
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // edge_source, edge_target, delta_x, delta_y, delta_z, zero fill
    output logic [OUT_DATA_W-1:0]           m_axis_tdata,
    // no_edge
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kgeb_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [kgeb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kgeb_pkg::*;

    localparam int C = COORD_BITS;
    localparam int R = RESIDUE_BITS;

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic              w_s_ready;
    logic [NODE_W-1:0] w_src, w_tgt;
    logic [C:0]        w_dx, w_dy, w_dz;
    logic              w_none, w_last;

    kgeb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_kind  (s_axis_tuser),
        .o_s_ready (w_s_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    kgeb_dpath #(
        .MAX_NODES    (MAX_NODES),
        .COORD_BITS   (COORD_BITS),
        .RESIDUE_BITS (RESIDUE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_node        (s_axis_tdata[NODE_W-1:0]),
        .i_pos_x       (s_axis_tdata[NODE_W+C-1:NODE_W]),
        .i_pos_y       (s_axis_tdata[NODE_W+2*C-1:NODE_W+C]),
        .i_pos_z       (s_axis_tdata[NODE_W+3*C-1:NODE_W+2*C]),
        .i_residue     (s_axis_tdata[NODE_W+3*C+R-1:NODE_W+3*C]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_edge_source (w_src),
        .o_edge_target (w_tgt),
        .o_delta_x     (w_dx),
        .o_delta_y     (w_dy),
        .o_delta_z     (w_dz),
        .o_no_edge     (w_none),
        .o_last_edge   (w_last)
    );

    // output packing
    assign s_axis_tready = w_s_ready;
    assign m_axis_tdata  = OUT_DATA_W'({w_dz, w_dy, w_dx, w_tgt, w_src});
    assign m_axis_tuser  = w_none;
    assign m_axis_tlast  = w_last;
    assign o_cfg_ready   = 1'b1;

endmodule

[rtl/kgeb_checker.sv]
// kgeb_checker: port level checks for the knn graph edge builder, bound to the top level
// depends on kgeb_pkg and knn_graph_edge_builder
`timescale 1ns / 1ps

module kgeb_checker #(
    parameter int OUT_DATA_W = 80
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast
);
    import kgeb_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a no-edge result closes its run
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("no-edge result without last");

    // a no-edge result has zero target and deltas
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata >> NODE_W) == '0)
        else $error("no-edge result carries data");

    // input ready is low right after a query is taken
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_QUERY |=> !s_axis_tready)
        else $error("input ready right after a query transfer");

endmodule

bind knn_graph_edge_builder kgeb_checker #(.OUT_DATA_W(OUT_DATA_W)) u_kgeb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
